// ----- hdl/nonrepeating_draw_with_buckets_defines.svh -----
// assertion macros for the nonrepeating draw block
// expects clk and rst_n in the scope of each use
`ifndef NONREPEATING_DRAW_WITH_BUCKETS_DEFINES_SVH
`define NONREPEATING_DRAW_WITH_BUCKETS_DEFINES_SVH

// condition holds at every clock edge out of reset
`define NDWB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define NDWB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define NDWB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ndwb_pkg.sv -----
// shared constants, codes and types for the nonrepeating draw block
// no dependencies
package ndwb_pkg;

  localparam int POOL_SIZE_DEF = 100;
  localparam int MAX_THR_DEF   = 8;
  localparam int REFILL_DEF    = 5;

  localparam int THR_W     = 7;
  localparam int THR_REG_W = 56;
  localparam int THR_CNT_W = 4;
  localparam int BUCKET_W  = 3;
  localparam int ROW_W     = 16;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;

  localparam logic REG_THR_COUNT = 1'b0;
  localparam logic REG_THRESHOLDS = 1'b1;

  localparam logic [1:0] OP_DRAW      = 2'd0;
  localparam logic [1:0] OP_MARK_LAST = 2'd1;
  localparam logic [1:0] OP_MARK_ITEM = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN
  } state_t;

endpackage

// ----- hdl/nonrepeating_draw_with_buckets.sv -----
// Flow: a mark word waits in the mark state for its bitmap row, then goes to the
// result register; a draw word scans rows from its start row, one 16-entry bitmap
// row read from the bitmap memory per cycle of the scan while the output does not
// stall. in_stall holds off a new word until the last one has been emitted.
// Reset: synchronous, clears control state; bitmap rows are emptied at once by
// per-row valid flags, so there is no clearing pass.
`include "nonrepeating_draw_with_buckets_defines.svh"

module nonrepeating_draw_with_buckets #(
  parameter int POOL_SIZE      = ndwb_pkg::POOL_SIZE_DEF,
  parameter int MAX_THRESHOLDS = ndwb_pkg::MAX_THR_DEF,
  parameter int REFILL_LIMIT   = ndwb_pkg::REFILL_DEF,
  localparam int ENTRY_W = $clog2(POOL_SIZE),
  localparam int CNT_W   = $clog2(POOL_SIZE + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [ENTRY_W-1:0]               in_random_value,
  input  logic [ENTRY_W-1:0]               in_mark_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ENTRY_W-1:0]               out_drawn_value,
  output logic [ndwb_pkg::BUCKET_W-1:0]    out_bucket,
  output logic [CNT_W-1:0]                 out_remaining,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ndwb_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [ndwb_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [ndwb_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import ndwb_pkg::*;

  localparam int NUM_ROWS = (POOL_SIZE + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int BIT_AW   = $clog2(ROW_W);
  localparam int CMP_W    = (ENTRY_W > THR_W) ? ENTRY_W : THR_W;
  localparam int NCNT_W   = $clog2(MAX_THRESHOLDS + 1);
  localparam int EXT_W    = MAX_THRESHOLDS * THR_W;
  localparam logic [ROW_AW-1:0]  LAST_ROW = ROW_AW'(NUM_ROWS - 1);
  localparam logic [CNT_W-1:0]   POOL_CNT = CNT_W'(POOL_SIZE);
  localparam logic [ENTRY_W:0]   POOL_E1  = (ENTRY_W + 1)'(POOL_SIZE);
  localparam logic [CMP_W-1:0]   TOP_VAL  = CMP_W'(POOL_SIZE - 1);

  function automatic logic [BUCKET_W-1:0] bucket_of(
    input logic [ENTRY_W-1:0]   v,
    input logic [THR_CNT_W-1:0] cnt,
    input logic [THR_REG_W-1:0] thr
  );
    logic [EXT_W-1:0]     ext;
    logic [NCNT_W-1:0]    n;
    logic [CMP_W-1:0]     t;
    logic [BUCKET_W-1:0]  res;
    ext = EXT_W'(thr);
    if (cnt == '0) begin
      n = NCNT_W'(1);
    end else if (32'(cnt) > MAX_THRESHOLDS) begin
      n = NCNT_W'(MAX_THRESHOLDS);
    end else begin
      n = NCNT_W'(cnt);
    end
    res = '0;
    for (int i = 1; i < MAX_THRESHOLDS; i++) begin
      t = CMP_W'(ext[i*THR_W +: THR_W]);
      if (t > TOP_VAL) begin
        t = TOP_VAL;
      end
      if (i < 32'(n) && CMP_W'(v) < t) begin
        res = BUCKET_W'(i);
      end
    end
    return res;
  endfunction

  state_t                 state_r, state_nxt;
  logic [ENTRY_W-1:0]     start_r, start_nxt;
  logic [ENTRY_W-1:0]     tgt_r, tgt_nxt;
  logic                   tgt_ok_r, tgt_ok_nxt;
  logic [ROW_AW-1:0]      cur_row_r, cur_row_nxt;
  logic [BIT_AW-1:0]      off_r, off_nxt;
  logic                   first_r, first_nxt;
  logic                   final_r, final_nxt;
  logic [NUM_ROWS-1:0]    row_valid_r, row_valid_nxt;
  logic [CNT_W-1:0]       remaining_r, remaining_nxt;
  logic [ENTRY_W-1:0]     last_r, last_nxt;
  logic [THR_CNT_W-1:0]   thr_cnt_r, thr_cnt_nxt;
  logic [THR_REG_W-1:0]   thr_r, thr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0]     out_value_r, out_value_nxt;
  logic [BUCKET_W-1:0]    out_bucket_r, out_bucket_nxt;
  logic [CNT_W-1:0]       out_rem_r, out_rem_nxt;

  logic [ROW_W-1:0]       used_mem [NUM_ROWS];
  logic [ROW_W-1:0]       mem_q_r;
  logic [ROW_AW-1:0]      rd_addr;
  logic                   mem_we;
  logic [ROW_W-1:0]       mem_wdata;

  logic                   in_acc, out_free, refill_now, cfg_we;
  logic [ENTRY_W:0]       pick_ext;
  logic [ENTRY_W-1:0]     start_in, tgt_in;
  logic                   tgt_ok_in;
  logic [ROW_W-1:0]       row_data, in_pool, window, free;
  logic                   found;
  logic [BIT_AW-1:0]      pos;
  logic [ROW_AW-1:0]      next_row, start_row;
  logic                   emit;
  logic [ENTRY_W-1:0]     emit_value;

  // handshake and input decode
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign refill_now = (32'(remaining_r) < REFILL_LIMIT);

  assign pick_ext  = {1'b0, in_random_value};
  assign start_in  = (pick_ext >= POOL_E1) ? ENTRY_W'(pick_ext - POOL_E1) : in_random_value;
  assign tgt_in    = (in_opcode == OP_MARK_LAST) ? last_r : in_mark_item;
  assign tgt_ok_in = (in_opcode == OP_MARK_LAST) ||
                     ((in_opcode == OP_MARK_ITEM) && ({1'b0, in_mark_item} < POOL_E1));

  // row scan
  assign row_data  = row_valid_r[cur_row_r] ? mem_q_r : '0;
  assign start_row = ROW_AW'(start_r >> BIT_AW);
  assign next_row  = (cur_row_r == LAST_ROW) ? '0 : cur_row_r + ROW_AW'(1);

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      in_pool[b] = (32'({cur_row_r, BIT_AW'(b)}) < POOL_SIZE);
      if (first_r) begin
        window[b] = (BIT_AW'(b) >= off_r);
      end else if (final_r) begin
        window[b] = (BIT_AW'(b) < off_r);
      end else begin
        window[b] = 1'b1;
      end
    end
  end

  assign free  = ~row_data & in_pool & window;
  assign found = |free;

  always_comb begin
    pos = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        pos = BIT_AW'(b);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_opcode == OP_DRAW) ? ST_SCAN : ST_MARK;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if ((found || final_r) && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    start_nxt     = start_r;
    tgt_nxt       = tgt_r;
    tgt_ok_nxt    = tgt_ok_r;
    cur_row_nxt   = cur_row_r;
    off_nxt       = off_r;
    first_nxt     = first_r;
    final_nxt     = final_r;
    row_valid_nxt = row_valid_r;
    remaining_nxt = remaining_r;
    last_nxt      = last_r;
    rd_addr       = cur_row_r;
    mem_we        = 1'b0;
    mem_wdata     = row_data;
    emit          = 1'b0;
    emit_value    = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          start_nxt  = start_in;
          tgt_nxt    = tgt_in;
          tgt_ok_nxt = tgt_ok_in;
          first_nxt  = 1'b1;
          off_nxt    = BIT_AW'(start_in);
          if (in_opcode == OP_DRAW) begin
            rd_addr   = ROW_AW'(start_in >> BIT_AW);
            final_nxt = 1'b0;
            if (refill_now) begin
              row_valid_nxt = '0;
              remaining_nxt = POOL_CNT;
            end
          end else begin
            rd_addr = ROW_AW'(tgt_in >> BIT_AW);
          end
          cur_row_nxt = rd_addr;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          emit = 1'b1;
          if (tgt_ok_r && !row_data[BIT_AW'(tgt_r)]) begin
            mem_we                   = 1'b1;
            mem_wdata[BIT_AW'(tgt_r)] = 1'b1;
            row_valid_nxt[cur_row_r] = 1'b1;
            if (remaining_r != '0) begin
              remaining_nxt = remaining_r - CNT_W'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_value = ENTRY_W'({cur_row_r, pos});
            last_nxt   = emit_value;
          end
        end else if (final_r) begin
          // whole pool used: empty it and take the start entry
          if (out_free) begin
            emit          = 1'b1;
            emit_value    = start_r;
            last_nxt      = start_r;
            row_valid_nxt = '0;
            remaining_nxt = POOL_CNT;
          end
        end else begin
          rd_addr     = next_row;
          cur_row_nxt = next_row;
          first_nxt   = 1'b0;
          final_nxt   = (next_row == start_row);
        end
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_bucket_nxt = out_bucket_r;
    out_rem_nxt    = out_rem_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = emit_value;
      out_bucket_nxt = bucket_of(emit_value, thr_cnt_r, thr_r);
      out_rem_nxt    = remaining_nxt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_value_r;
  assign out_bucket      = out_bucket_r;
  assign out_remaining   = out_rem_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    thr_cnt_nxt = thr_cnt_r;
    thr_nxt     = thr_r;
    if (cfg_we) begin
      case (cfg_paddr[3])
        REG_THR_COUNT:  thr_cnt_nxt = cfg_pwdata[THR_CNT_W-1:0];
        REG_THRESHOLDS: thr_nxt     = cfg_pwdata[THR_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      REG_THR_COUNT:  cfg_prdata = CFG_DW'(thr_cnt_r);
      REG_THRESHOLDS: cfg_prdata = CFG_DW'(thr_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[cur_row_r] <= mem_wdata;
    end
    mem_q_r <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_ok_r    <= 1'b0;
      cur_row_r   <= '0;
      off_r       <= '0;
      first_r     <= 1'b0;
      final_r     <= 1'b0;
      row_valid_r <= '0;
      remaining_r <= POOL_CNT;
      last_r      <= '0;
      thr_cnt_r   <= THR_CNT_W'(1);
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_ok_r    <= tgt_ok_nxt;
      cur_row_r   <= cur_row_nxt;
      off_r       <= off_nxt;
      first_r     <= first_nxt;
      final_r     <= final_nxt;
      row_valid_r <= row_valid_nxt;
      remaining_r <= remaining_nxt;
      last_r      <= last_nxt;
      thr_cnt_r   <= thr_cnt_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    tgt_r        <= tgt_nxt;
    out_value_r  <= out_value_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  `NDWB_ASSERT_ALWAYS(a_rem_bound, remaining_r <= POOL_CNT, "remaining count above pool size")
  `NDWB_ASSERT_IMP(a_out_range, out_valid, 32'(out_drawn_value) < POOL_SIZE, "word out of pool")
  `NDWB_ASSERT_NXT(a_refill, in_acc && in_opcode == OP_DRAW && refill_now, remaining_r == POOL_CNT, "draw refill missed")
  `NDWB_ASSERT_NXT(a_mark_no_rise, state_r == ST_MARK, remaining_r <= $past(remaining_r), "mark raised remaining")

endmodule

// ----- tb/sv/tb_nonrepeating_draw_with_buckets.sv -----
// testbench for nonrepeating_draw_with_buckets: directed words with stated results, then
// random draw and mark words under several threshold settings checked against a predictor
// depends on ndwb_pkg and the block's rtl only
module tb_nonrepeating_draw_with_buckets;
  import ndwb_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int PHASE_WORDS = 88;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [6:0]          drawn_value;
    logic [BUCKET_W-1:0] bucket;
    logic [6:0]          remaining;
  } draw_word_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] pick;
    logic [6:0] item;
    draw_word_t want;
  } dir_row_t;

  typedef struct packed {
    logic [THR_CNT_W-1:0] count;
    logic [THR_REG_W-1:0] thr;
  } setting_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode = OP_DRAW;
  logic [6:0]          in_random_value = '0;
  logic [6:0]          in_mark_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [6:0]          out_drawn_value;
  logic [BUCKET_W-1:0] out_bucket;
  logic [6:0]          out_remaining;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // side information that travels with each word
  bit         row_typed = 1'b0;
  draw_word_t row_want = '0;

  // predictor state and configuration
  logic [POOL_SIZE_DEF-1:0] used_bits = '0;
  int                       left_count = POOL_SIZE_DEF;
  int                       last_pick = 0;
  logic [THR_CNT_W-1:0]     thr_count = 4'd1;
  logic [THR_REG_W-1:0]     thr_bits = '0;

  draw_word_t awaited_words[$];
  int         fail_count = 0;
  int         send_pct = 8;
  int         recv_pct = 82;
  bit         hold_req = 1'b0;
  bit         hold_seen = 1'b0;
  int         hold_left = 0;

  dir_row_t directed_rows[$] = '{
    {OP_DRAW,      7'd0,   7'd0,   7'd0,  3'd0, 7'd100},
    {OP_MARK_LAST, 7'd0,   7'd0,   7'd0,  3'd0, 7'd99},
    {OP_DRAW,      7'd0,   7'd127, 7'd1,  3'd0, 7'd99},
    {OP_MARK_ITEM, 7'd127, 7'd99,  7'd1,  3'd0, 7'd98},
    {OP_DRAW,      7'd99,  7'd0,   7'd1,  3'd0, 7'd98},
    {OP_MARK_ITEM, 7'd0,   7'd127, 7'd1,  3'd0, 7'd98},
    {OP_MARK_ITEM, 7'd0,   7'd100, 7'd1,  3'd0, 7'd98},
    {OP_IGNORED,   7'd127, 7'd5,   7'd1,  3'd0, 7'd98},
    {OP_MARK_LAST, 7'd0,   7'd0,   7'd1,  3'd0, 7'd97},
    {OP_MARK_LAST, 7'd0,   7'd0,   7'd1,  3'd0, 7'd97},
    {OP_MARK_ITEM, 7'd0,   7'd1,   7'd1,  3'd0, 7'd97},
    {OP_DRAW,      7'd127, 7'd0,   7'd27, 3'd0, 7'd97},
    {OP_DRAW,      7'd100, 7'd0,   7'd2,  3'd0, 7'd97},
    {OP_DRAW,      7'd126, 7'd0,   7'd26, 3'd0, 7'd97},
    {OP_MARK_ITEM, 7'd0,   7'd64,  7'd26, 3'd0, 7'd96},
    {OP_DRAW,      7'd64,  7'd0,   7'd65, 3'd0, 7'd96},
    {OP_IGNORED,   7'd0,   7'd0,   7'd65, 3'd0, 7'd96},
    {OP_MARK_LAST, 7'd0,   7'd0,   7'd65, 3'd0, 7'd95},
    {OP_DRAW,      7'd63,  7'd0,   7'd63, 3'd0, 7'd95}
  };

  nonrepeating_draw_with_buckets dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_random_value (in_random_value),
    .in_mark_item    (in_mark_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value),
    .out_bucket      (out_bucket),
    .out_remaining   (out_remaining),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3200000;
    $display("simulation failed");
    $finish;
  end

  function automatic void refill_pool();
    used_bits = '0;
    left_count = POOL_SIZE_DEF;
  endfunction

  function automatic void claim_entry(int e);
    if (e < POOL_SIZE_DEF && !used_bits[e]) begin
      used_bits[e] = 1'b1;
      if (left_count > 0) left_count--;
    end
  endfunction

  function automatic draw_word_t predict_draw(logic [1:0] op, logic [6:0] pick,
                                              logic [6:0] item);
    int v, start, n, k, t;
    draw_word_t r;
    if (op == OP_DRAW) begin
      start = pick % POOL_SIZE_DEF;
      if (left_count < REFILL_DEF) refill_pool();
      v = start;
      while (used_bits[v]) begin
        v = (v + 1) % POOL_SIZE_DEF;
        if (v == start) refill_pool();
      end
      last_pick = v;
    end else begin
      if (op == OP_MARK_LAST) claim_entry(last_pick);
      else if (op == OP_MARK_ITEM) claim_entry(item);
      v = last_pick;
    end
    // walk down from the highest threshold in use
    n = thr_count;
    if (n == 0) n = 1;
    if (n > MAX_THR_DEF) n = MAX_THR_DEF;
    k = n - 1;
    while (k != 0) begin
      t = int'(thr_bits[k*THR_W +: THR_W]);
      if (t > POOL_SIZE_DEF - 1) t = POOL_SIZE_DEF - 1;
      if (v < t) break;
      k--;
    end
    r.drawn_value = 7'(v);
    r.bucket = BUCKET_W'(k);
    r.remaining = 7'(left_count);
    return r;
  endfunction

  function automatic logic [THR_REG_W-1:0] pack_thr(int t0, int t1, int t2, int t3,
                                                    int t4, int t5, int t6, int t7);
    return {7'(t7), 7'(t6), 7'(t5), 7'(t4), 7'(t3), 7'(t2), 7'(t1), 7'(t0)};
  endfunction

  function automatic logic [6:0] rand_pick();
    if ($urandom_range(99) < 85) return 7'($urandom_range(POOL_SIZE_DEF - 1));
    return 7'($urandom_range(127, POOL_SIZE_DEF));
  endfunction

  always @(posedge clk) begin : score
    draw_word_t want, got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = predict_draw(in_opcode, in_random_value, in_mark_item);
        awaited_words.push_back(row_typed ? row_want : want);
      end
      if (out_valid && !out_stall) begin
        got = {out_drawn_value, out_bucket, out_remaining};
        if (awaited_words.size() == 0) begin
          $error("result word with nothing awaited: drawn_value %0d", out_drawn_value);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          if (got.drawn_value !== want.drawn_value) begin
            $error("drawn_value: expected %0d, got %0d", want.drawn_value, got.drawn_value);
            fail_count++;
          end
          if (got.bucket !== want.bucket) begin
            $error("bucket: expected %0d, got %0d", want.bucket, got.bucket);
            fail_count++;
          end
          if (got.remaining !== want.remaining) begin
            $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [6:0] pick,
                           input logic [6:0] item, input bit typed, input draw_word_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_random_value <= pick;
    in_mark_item <= item;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves psel high so that two writes run back to back
  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_THR_COUNT) thr_count = value[THR_CNT_W-1:0];
    else thr_bits = value[THR_REG_W-1:0];
  endtask

  task automatic write_settings(input setting_t s);
    write_reg(REG_THR_COUNT, CFG_DW'(s.count));
    write_reg(REG_THRESHOLDS, CFG_DW'(s.thr));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic random_words(input int budget);
    int done = 0;
    int sel;
    while (done < budget) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        // draw followed by marking it, the usual game sequence
        send_word(OP_DRAW, rand_pick(), 7'($urandom), 1'b0, '0);
        send_word(OP_MARK_LAST, 7'($urandom), 7'($urandom), 1'b0, '0);
        done += 2;
      end else if (sel < 75) begin
        send_word(OP_MARK_ITEM, 7'($urandom), 7'($urandom_range(POOL_SIZE_DEF - 1)),
                  1'b0, '0);
        done++;
      end else if (sel < 85) begin
        send_word(OP_DRAW, rand_pick(), 7'($urandom), 1'b0, '0);
        done++;
      end else if (sel < 92) begin
        send_word(OP_MARK_LAST, 7'($urandom), 7'($urandom), 1'b0, '0);
        done++;
      end else if (sel < 96) begin
        send_word(OP_MARK_ITEM, 7'($urandom), 7'($urandom_range(127, POOL_SIZE_DEF)),
                  1'b0, '0);
        done++;
      end else begin
        send_word(OP_IGNORED, 7'($urandom), 7'($urandom), 1'b0, '0);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    setting_t settings[$];
    settings.push_back({4'd4, pack_thr(0, 25, 50, 75, 0, 0, 0, 0)});
    settings.push_back({4'd0, pack_thr(0, 30, 60, 90, 95, 96, 97, 98)});
    settings.push_back({4'd8, pack_thr(5, 15, 30, 45, 60, 75, 90, 99)});
    settings.push_back({4'd15, pack_thr(0, 12, 25, 37, 50, 62, 75, 87)});
    settings.push_back({4'd8, pack_thr(127, 127, 127, 127, 127, 127, 127, 127)});
    settings.push_back({4'd2, pack_thr(0, 50, 0, 0, 0, 0, 0, 0)});
    settings.push_back({4'd8, pack_thr(90, 10, 80, 20, 70, 30, 60, 40)});
    settings.push_back({4'd8, pack_thr(0, 0, 0, 0, 0, 0, 0, 0)});
    settings.push_back({4'd1, pack_thr(127, 127, 127, 127, 127, 127, 127, 127)});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].pick, directed_rows[i].item,
                1'b1, directed_rows[i].want);

    for (int p = 0; p < settings.size(); p++) begin
      wait_all_results();
      write_settings(settings[p]);
      send_pct = (p < 3) ? 8 : (p < 6) ? 82 : 0;
      recv_pct <= (p < 3) ? 82 : (p < 6) ? 8 : 0;
      random_words(PHASE_WORDS / 2);
      if (p == 4) wait_all_results();
      if (p == 6) hold_req <= ~hold_req;
      random_words(PHASE_WORDS / 2);
    end
    wait_all_results();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ndwb_pkg.sv
hdl/nonrepeating_draw_with_buckets.sv
tb/sv/tb_nonrepeating_draw_with_buckets.sv
